// ===== rtl/iovs_pkg.sv =====
// Package for the implicit octree voxel store: sequencer states and fixed widths.
// No dependencies.
`default_nettype none
package iovs_pkg;
  localparam int LEVELS    = 4;
  localparam int TYPE_BITS = 8;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_WR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DREAD,
    ST_DWAIT,
    ST_DCHECK,
    ST_SPLIT,
    ST_SPLIT_MARK,
    ST_SET,
    ST_MREAD,
    ST_MWAIT,
    ST_MCHECK,
    ST_DONE
  } iovs_state_t;
endpackage
`default_nettype wire

// ===== rtl/iovs_if.sv =====
// Valid/ready channel interfaces for the voxel store.
// No dependencies.
`default_nettype none
interface iovs_req_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [3:0] x_coord;
  logic [3:0] y_coord;
  logic [3:0] z_coord;
  logic [7:0] block_type;
  logic       merge_allowed;
  modport source(output valid, kind, x_coord, y_coord, z_coord, block_type, merge_allowed,
                 input ready);
  modport sink(input valid, kind, x_coord, y_coord, z_coord, block_type, merge_allowed,
               output ready);
endinterface

interface iovs_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  leaf_type;
  logic [12:0] node_index;
  logic [2:0]  leaf_size_log;
  modport source(output valid, leaf_type, node_index, leaf_size_log, input ready);
  modport sink(input valid, leaf_type, node_index, leaf_size_log, output ready);
endinterface
`default_nettype wire

// ===== rtl/iovs_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none
module iovs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4681
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/implicit_octree_voxel_store.sv =====
// Top level of the implicit octree voxel store: sequencer around one node-type RAM.
// Depends on iovs_pkg, iovs_if and iovs_ram.
//
//  channel   | dir | handshake    | payload
//  req       | in  | valid/ready  | kind, x/y/z_coord, block_type, merge_allowed
//  rsp       | out | valid/ready  | leaf_type, node_index, leaf_size_log
//  cfg       | in  | cfg_we       | cfg_data = mixed_marker
//
// A request is accepted while idle; each level on the way down is a node read (issue, wait,
// check). A write that must go deeper splits each level (8 child writes and a marker write),
// then writes the voxel. Each merge level issues a read, checks the 8 siblings (wait, check)
// and writes the parent; a failing sibling check ends the merge early.
// Reset clears only the root entry, by a write while init_done is low; other entries are
// written before they are read. The sequencer holds in its last state while an
// earlier result still waits in the output register; requests are taken only when idle.
`default_nettype none
module implicit_octree_voxel_store
  import iovs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_data,
  iovs_req_if.sink        req,
  iovs_rsp_if.source      rsp
);
  localparam int NODES = ((1 << (3 * (LEVELS + 1))) - 1) / 7;
  localparam int AW    = $clog2(NODES);
  localparam int DW    = $clog2(LEVELS + 1);

  iovs_state_t state, state_next;
  logic [7:0]           mixed_marker;
  logic [AW-1:0]        node;
  logic [DW-1:0]        depth;
  logic [DW-1:0]        up;
  logic [3:0]           cnt;
  logic [TYPE_BITS-1:0] old_t;
  logic                 same;
  logic                 kind_r, merge_r;
  logic [3:0]           x_r, y_r, z_r;
  logic [TYPE_BITS-1:0] bt_r;
  logic                 init_done;

  logic                 we;
  logic [AW-1:0]        addr;
  logic [TYPE_BITS-1:0] wdata, rdata;
  logic [TYPE_BITS-1:0] marker;
  logic [2:0]           slot;
  logic [AW-1:0]        first, parent;
  int                   sh;

  iovs_ram #(.WIDTH(TYPE_BITS), .DEPTH(NODES)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign marker = mixed_marker[TYPE_BITS-1:0];

  always_comb begin
    sh = LEVELS - 1 - int'(depth);
    if (sh < 0) sh = 0;
    slot = {z_r[sh], y_r[sh], x_r[sh]};
    first = AW'({node, 3'b000} + 1);
    parent = AW'((node - AW'(1)) >> 3);
  end

  assign req.ready = init_done && state == ST_IDLE;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (req.valid && req.ready) state_next = ST_DREAD;
      ST_DREAD:  state_next = ST_DWAIT;
      ST_DWAIT:  state_next = ST_DCHECK;
      ST_DCHECK: begin
        if (int'(depth) < LEVELS && rdata == marker) state_next = ST_DREAD;
        else if (kind_r == KIND_READ || bt_r == marker || rdata == bt_r) state_next = ST_DONE;
        else if (int'(depth) < LEVELS) state_next = ST_SPLIT;
        else state_next = ST_SET;
      end
      ST_SPLIT:      if (cnt == 4'd7) state_next = ST_SPLIT_MARK;
      ST_SPLIT_MARK: state_next = (int'(depth) == LEVELS - 1) ? ST_SET : ST_SPLIT;
      ST_SET:        state_next = (merge_r && node != '0 && bt_r != marker) ? ST_MREAD : ST_DONE;
      ST_MREAD:      state_next = ST_MWAIT;
      ST_MWAIT:      state_next = ST_MCHECK;
      ST_MCHECK: begin
        if (!same || rdata != bt_r) state_next = ST_DONE;
        else if (cnt == 4'd7) state_next = ST_SET;
        else state_next = ST_MWAIT;
      end
      ST_DONE: if (!rsp.valid || rsp.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    we = 1'b0;
    addr = node;
    wdata = bt_r;
    case (state)
      ST_SPLIT: begin
        we = 1'b1; addr = AW'(first + AW'(cnt)); wdata = old_t;
      end
      ST_SPLIT_MARK: begin
        we = 1'b1; wdata = marker;
      end
      ST_SET: we = 1'b1;
      ST_MREAD, ST_MWAIT, ST_MCHECK: addr = AW'(((parent) << 3) + 1 + AW'(cnt));
      default: ;
    endcase
    if (!init_done) begin
      we = 1'b1; addr = '0; wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mixed_marker <= 8'hFF;
      init_done <= 1'b0;
      rsp.valid <= 1'b0;
      node <= '0;
      depth <= '0;
      up <= '0;
    end else begin
      init_done <= 1'b1;
      state <= state_next;
      if (cfg_we) mixed_marker <= cfg_data;
      if (rsp.valid && rsp.ready && state != ST_DONE) rsp.valid <= 1'b0;
      case (state)
        ST_IDLE: if (req.valid && req.ready) begin
          kind_r <= req.kind; merge_r <= req.merge_allowed;
          x_r <= req.x_coord; y_r <= req.y_coord; z_r <= req.z_coord;
          bt_r <= req.block_type[TYPE_BITS-1:0];
          node <= '0; depth <= '0; up <= '0;
        end
        ST_DCHECK: begin
          old_t <= rdata;
          cnt <= '0;
          if (int'(depth) < LEVELS && rdata == marker) begin
            node <= AW'(first + AW'(slot)); depth <= depth + 1'b1;
          end else if (kind_r == KIND_READ || bt_r == marker || rdata == bt_r) begin
            // Result for reads and no-op writes uses the leaf's own type.
            bt_r <= rdata;
          end
        end
        ST_SPLIT: cnt <= cnt + 4'd1;
        ST_SPLIT_MARK: begin
          cnt <= '0; node <= AW'(first + AW'(slot)); depth <= depth + 1'b1;
        end
        ST_SET: begin
          cnt <= '0; same <= 1'b1;
        end
        ST_MWAIT: cnt <= cnt;
        ST_MCHECK: begin
          if (rdata != bt_r) same <= 1'b0;
          if (same && rdata == bt_r) begin
            if (cnt == 4'd7) begin
              node <= parent; up <= up + 1'b1; depth <= depth - 1'b1;
            end
            cnt <= cnt + 4'd1;
          end
        end
        ST_DONE: if (!rsp.valid || rsp.ready) begin
          rsp.valid <= 1'b1;
          rsp.leaf_type <= 8'(bt_r);
          rsp.node_index <= 13'(node);
          rsp.leaf_size_log <= (kind_r == KIND_WR && state_next == ST_IDLE && up != '0)
                               ? 3'(up) : 3'(LEVELS - int'(depth));
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !req.ready) else $error("ready while busy");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    int'(depth) <= LEVELS) else $error("depth overrun");
  a_split_write: assert property (@(posedge clk) disable iff (rst)
    state == ST_SPLIT |-> we) else $error("split without write");
`endif
endmodule
`default_nettype wire
